// File: hdl/ectc_pkg.sv
// Shared constants, types and the month table of the epoch to calendar converter.
package ectc_pkg;

   // Field widths
   localparam int EPOCH_W = 33;
   localparam int TZ_W    = 5;
   localparam int HOURS_W = 21;
   localparam int SUM_W   = EPOCH_W + 2;

   // Seconds per hour for the offset
   localparam logic signed [SUM_W-1:0] SEC_PER_HOUR = 35'sd3600;

   // floor(x / 225) for x < 2**29 as (x * HOUR_RECIP) >> HOUR_SHIFT
   localparam logic [29:0] HOUR_RECIP = 30'd610839794;
   localparam int          HOUR_SHIFT = 37;

   // floor(x / 15) for x < 2**10 as (x * MIN_RECIP) >> MIN_SHIFT
   localparam logic [10:0] MIN_RECIP = 11'd1093;
   localparam int          MIN_SHIFT = 14;

   // floor(x / 4383) for x < 2**18 as (x * PERIOD_RECIP) >> PERIOD_SHIFT
   localparam logic [19:0] PERIOD_RECIP = 20'd979915;
   localparam int          PERIOD_SHIFT = 32;

   // floor(x / 3) for x < 2**11 as (x * DAY_RECIP) >> DAY_SHIFT
   localparam logic [9:0] DAY_RECIP = 10'd683;
   localparam int         DAY_SHIFT = 11;

   // Hour counts within a four-year period (1461 days)
   localparam logic [HOURS_W-1:0] HOURS_PER_PERIOD = 21'd35064;
   localparam logic [15:0] YEAR1_START = 16'd8760;
   localparam logic [15:0] YEAR2_START = 16'd17520;
   localparam logic [15:0] YEAR3_START = 16'd26304;

   // A period starts at a year with (year - 1900) mod 4 == 2
   localparam logic [1:0] LEAP_YEAR_IN_PERIOD = 2'd2;
   localparam logic [7:0] BASE_YEAR           = 8'd70;
   localparam logic [8:0] LEAP_DAY            = 9'd60;
   localparam logic [3:0] FEBRUARY            = 4'd1;
   localparam logic [4:0] FEB_LAST_LEAP       = 5'd29;
   localparam int         MONTHS              = 12;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
   } ectc_ms_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] day;
   } ectc_result_type;

   // Day of year (from 0) on which each month of a common year starts
   function automatic logic [8:0] month_start(input logic [3:0] mon);
      logic [8:0] d;
      case (mon)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// File: hdl/ectc_time_split.sv
// Time split: offset and clamp, then seconds into hours, minutes and seconds (three stages).
module ectc_time_split (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [ectc_pkg::TZ_W-1:0]       tz_offset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic signed [ectc_pkg::EPOCH_W-1:0]    epoch_seconds,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [ectc_pkg::HOURS_W-1:0]           hours,
   output ectc_pkg::ectc_ms_type                  ms
);
   import ectc_pkg::*;

   logic                      v1_ff, v2_ff, v3_ff;
   logic                      rdy1, rdy2, rdy3;
   logic signed [SUM_W-1:0]   sum;
   logic [EPOCH_W-1:0]        t_in, t_ff;
   logic [EPOCH_W-5:0]        x;
   logic [58:0]               hour_prod;
   logic [HOURS_W-1:0]        hours_in, hours2_ff, hours3_ff;
   logic [7:0]                xlo_ff;
   logic [3:0]                tlo_ff;
   logic [7:0]                rem225;
   logic [11:0]               sec_of_hour;
   logic [20:0]               min_prod;
   logic [5:0]                min_val;
   logic [11:0]               sec_full;
   ectc_ms_type               ms_in, ms_ff;

   // Stall chain: a stage moves when it is empty or the next one takes its word
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // Stage 1: add the offset and clamp a negative sum to zero
   always_comb begin
      sum  = SUM_W'(epoch_seconds) + SUM_W'(tz_offset) * SEC_PER_HOUR;
      t_in = sum[SUM_W-1] ? '0 : sum[EPOCH_W-1:0];
   end

   // Stage 2: whole hours as floor((t / 16) / 225)
   always_comb begin
      x         = t_ff[EPOCH_W-1:4];
      hour_prod = 59'(x) * 59'(HOUR_RECIP);
      hours_in  = hour_prod[HOUR_SHIFT+HOURS_W-1:HOUR_SHIFT];
   end

   // Stage 3: second of hour from low bits, since (q * 225) mod 256 == -(q * 31) mod 256
   always_comb begin
      rem225       = xlo_ff + {hours2_ff[2:0], 5'b0} - hours2_ff[7:0];
      sec_of_hour  = {rem225, tlo_ff};
      min_prod     = 21'(sec_of_hour[11:2]) * 21'(MIN_RECIP);
      min_val      = min_prod[MIN_SHIFT+5:MIN_SHIFT];
      sec_full     = sec_of_hour - {min_val, 6'b0} + 12'({min_val, 2'b0});
      ms_in.second = sec_full[5:0];
      ms_in.minute = min_val;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Advance payload; hold on stall
   always_ff @(posedge clock) begin
      if (rdy1) t_ff <= t_in;
      if (rdy2) begin
         hours2_ff <= hours_in;
         xlo_ff    <= t_ff[11:4];
         tlo_ff    <= t_ff[3:0];
      end
      if (rdy3) begin
         hours3_ff <= hours2_ff;
         ms_ff     <= ms_in;
      end
   end

   assign out_valid = v3_ff;
   assign hours     = hours3_ff;
   assign ms        = ms_ff;

   // Remainder of the hour split must stay below 225
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (8'(xlo_ff + {hours2_ff[2:0], 5'b0} - hours2_ff[7:0]) < 8'd225))
      else $error("hour split remainder out of range");

   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (ms_ff.second < 6'd60 && ms_ff.minute < 6'd60))
      else $error("minute or second out of range");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !out_ready) |=> (v3_ff && $stable(hours3_ff) && $stable(ms_ff)))
      else $error("stalled word changed");

endmodule

// File: hdl/ectc_date_split.sv
// Date split: hours into year, hour of day, month and day of month (four stages).
module ectc_date_split (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ectc_pkg::HOURS_W-1:0]  hours,
   input  ectc_pkg::ectc_ms_type         ms,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ectc_pkg::ectc_result_type     result
);
   import ectc_pkg::*;

   logic                  va_ff, vb_ff, vc_ff, vd_ff;
   logic                  rdya, rdyb, rdyc, rdyd;

   // Stage A: period index
   logic [37:0]           period_prod;
   logic [5:0]            period_in, period_ff;
   logic [HOURS_W-1:0]    hours_a_ff;
   ectc_ms_type           ms_a_ff, ms_b_ff, ms_c_ff;

   // Stage B: year within period
   logic [HOURS_W-1:0]    rem_full;
   logic [15:0]           rem_hours;
   logic [15:0]           year_base;
   logic [1:0]            year_off;
   logic [13:0]           hy_in, hy_ff;
   logic [7:0]            year_in, year_b_ff, year_c_ff;
   logic                  leap_in, leap_b_ff, leap_c_ff;

   // Stage C: hour of day and day of year
   logic [20:0]           day_prod;
   logic [8:0]            day_idx;
   logic [13:0]           hour_full;
   logic [4:0]            hour_in, hour_c_ff;
   logic [8:0]            day_in, day_ff;

   // Stage D: month lookup
   logic [8:0]            day_adj;
   logic [3:0]            mon_cnt;
   logic [8:0]            dom_full;
   ectc_result_type       result_in, result_ff;

   // Stall chain
   assign rdyd     = !vd_ff || out_ready;
   assign rdyc     = !vc_ff || rdyd;
   assign rdyb     = !vb_ff || rdyc;
   assign rdya     = !va_ff || rdyb;
   assign in_ready = rdya;

   // Stage A: four-year periods as floor((hours / 8) / 4383)
   always_comb begin
      period_prod = 38'(hours[HOURS_W-1:3]) * 38'(PERIOD_RECIP);
      period_in   = period_prod[PERIOD_SHIFT+5:PERIOD_SHIFT];
   end

   // Stage B: pick the year inside the period
   always_comb begin
      rem_full  = hours_a_ff - HOURS_W'(period_ff) * HOURS_PER_PERIOD;
      rem_hours = rem_full[15:0];
      if (rem_hours < YEAR1_START) begin
         year_off  = 2'd0;
         year_base = '0;
      end else if (rem_hours < YEAR2_START) begin
         year_off  = 2'd1;
         year_base = YEAR1_START;
      end else if (rem_hours < YEAR3_START) begin
         year_off  = 2'd2;
         year_base = YEAR2_START;
      end else begin
         year_off  = 2'd3;
         year_base = YEAR3_START;
      end
      hy_in   = 14'(rem_hours - year_base);
      year_in = BASE_YEAR + {period_ff, 2'b00} + 8'(year_off);
      leap_in = (year_off == LEAP_YEAR_IN_PERIOD);
   end

   // Stage C: day of year as floor((hy / 8) / 3), hour as the rest
   always_comb begin
      day_prod  = 21'(hy_ff[13:3]) * 21'(DAY_RECIP);
      day_idx   = day_prod[DAY_SHIFT+8:DAY_SHIFT];
      hour_full = hy_ff - 14'({day_idx, 4'b0}) - 14'({day_idx, 3'b0});
      hour_in   = hour_full[4:0];
      day_in    = day_idx + 9'd1;
   end

   // Stage D: leap day, then count month starts below the day
   always_comb begin
      day_adj = (leap_c_ff && day_ff > LEAP_DAY) ? day_ff - 9'd1 : day_ff;
      mon_cnt = '0;
      for (int k = 1; k < MONTHS; k++) begin
         mon_cnt = mon_cnt + 4'(month_start(4'(k)) < day_adj);
      end
      dom_full         = day_adj - month_start(mon_cnt);
      result_in.second = ms_c_ff.second;
      result_in.minute = ms_c_ff.minute;
      result_in.hour   = hour_c_ff;
      result_in.year   = year_c_ff;
      if (leap_c_ff && day_ff == LEAP_DAY) begin
         result_in.month = FEBRUARY;
         result_in.day   = FEB_LAST_LEAP;
      end else begin
         result_in.month = mon_cnt;
         result_in.day   = dom_full[4:0];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdya) va_ff <= in_valid;
         if (rdyb) vb_ff <= va_ff;
         if (rdyc) vc_ff <= vb_ff;
         if (rdyd) vd_ff <= vc_ff;
      end
   end

   // Advance payload; hold on stall
   always_ff @(posedge clock) begin
      if (rdya) begin
         period_ff  <= period_in;
         hours_a_ff <= hours;
         ms_a_ff    <= ms;
      end
      if (rdyb) begin
         hy_ff     <= hy_in;
         year_b_ff <= year_in;
         leap_b_ff <= leap_in;
         ms_b_ff   <= ms_a_ff;
      end
      if (rdyc) begin
         hour_c_ff <= hour_in;
         day_ff    <= day_in;
         year_c_ff <= year_b_ff;
         leap_c_ff <= leap_b_ff;
         ms_c_ff   <= ms_b_ff;
      end
      if (rdyd) result_ff <= result_in;
   end

   assign out_valid = vd_ff;
   assign result    = result_ff;

   // Day of year stays within the length of its year
   a_hy_range: assert property (@(posedge clock) disable iff (reset)
      vc_ff |-> ((leap_c_ff && day_ff <= 9'd366) || (!leap_c_ff && day_ff <= 9'd365)))
      else $error("day of year out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      vd_ff |-> (result_ff.month < 4'd12 && result_ff.day != 5'd0 && result_ff.hour < 5'd24))
      else $error("date field out of range");

   a_leap_day: assert property (@(posedge clock) disable iff (reset)
      (vd_ff && result_ff.month == FEBRUARY && result_ff.day == FEB_LAST_LEAP)
         |-> (result_ff.year[1:0] == 2'b00))
      else $error("February 29 in a common year");

endmodule

// File: hdl/epoch_seconds_to_calendar_core.sv
// Throughput: one word per cycle; the path is a seven-stage pipeline with stall on rsp_ready.
// The hour split multiplier (29 x 30 bits) sets the depth of the second stage.
// Reset: synchronous, clears all stage valid bits and sets the time-zone offset to zero.
// Top level: offset register, time split and date split.
module epoch_seconds_to_calendar_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic signed [ectc_pkg::TZ_W-1:0]     csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ectc_pkg::EPOCH_W-1:0]  req_epoch_seconds,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [5:0]                           rsp_second,
   output logic [5:0]                           rsp_minute,
   output logic [4:0]                           rsp_hour,
   output logic [7:0]                           rsp_year_since_1900,
   output logic [3:0]                           rsp_month,
   output logic [4:0]                           rsp_day_of_month
);
   import ectc_pkg::*;

   logic signed [TZ_W-1:0]  tz_offset_hours_ff, tz_offset_hours_in;
   logic                    mid_valid, mid_ready;
   logic [HOURS_W-1:0]      mid_hours;
   ectc_ms_type             mid_ms;
   ectc_result_type         result;

   // Load the offset register on a write
   assign tz_offset_hours_in = csr_wr_en ? csr_wr_data : tz_offset_hours_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_offset_hours_ff <= '0;
      end else begin
         tz_offset_hours_ff <= tz_offset_hours_in;
      end
   end

   ectc_time_split u_time (
      .clock         (clock),
      .reset         (reset),
      .tz_offset     (tz_offset_hours_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .epoch_seconds (req_epoch_seconds),
      .out_valid     (mid_valid),
      .out_ready     (mid_ready),
      .hours         (mid_hours),
      .ms            (mid_ms)
   );

   ectc_date_split u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .hours     (mid_hours),
      .ms        (mid_ms),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .result    (result)
   );

   assign rsp_second          = result.second;
   assign rsp_minute          = result.minute;
   assign rsp_hour            = result.hour;
   assign rsp_year_since_1900 = result.year;
   assign rsp_month           = result.month;
   assign rsp_day_of_month    = result.day;

endmodule

// File: dv/epoch_seconds_to_calendar_core_tb.sv
// Self-checking testbench of the epoch seconds to calendar date converter.
`timescale 1ns / 1ps

class calendar_scoreboard;
   ectc_pkg::ectc_result_type pending_dates[$];
   int errors;
   int words_checked;

   function new();
      errors = 0;
      words_checked = 0;
   endfunction

   function int pending();
      return pending_dates.size();
   endfunction

   // Convert seconds plus the hour offset to a calendar date
   function ectc_pkg::ectc_result_type to_calendar(logic signed [32:0] secs,
                                                   logic signed [4:0] tz);
      longint sum;
      longint unsigned t, yr, hy, dom;
      int mon;
      int mlen[12];
      bit leap;
      ectc_pkg::ectc_result_type r;
      mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      sum = longint'(secs) + longint'(tz) * 64'sd3600;
      // clamp a negative sum to the epoch itself
      t = (sum < 0) ? 64'd0 : longint'(sum);
      r.second = 6'(t % 60);
      t = t / 60;
      r.minute = 6'(t % 60);
      t = t / 60;
      // whole four-year periods of 1461 days, then single years
      yr = (t / 35064) * 4 + 70;
      t = t % 35064;
      for (int i = 0; i < 4; i++) begin
         hy = 8760 + ((yr[1:0] == 2'd0) ? 24 : 0);
         if (t < hy) break;
         yr = yr + 1;
         t = t - hy;
      end
      leap = (yr[1:0] == 2'd0);
      r.hour = 5'(t % 24);
      dom = t / 24 + 1;
      mon = 0;
      // leap day stands alone; later days of a leap year shift back by one
      if (leap && dom == 60) begin
         mon = 1;
         dom = 29;
      end else begin
         if (leap && dom > 60) dom = dom - 1;
         while (mon < 11 && mlen[mon] < dom) begin
            dom = dom - mlen[mon];
            mon++;
         end
      end
      r.year = 8'(yr);
      r.month = 4'(mon);
      r.day = 5'(dom);
      return r;
   endfunction

   // Queue the date an accepted request word must produce
   function void note_request(logic signed [32:0] secs, logic signed [4:0] tz);
      pending_dates.push_back(to_calendar(secs, tz));
   endfunction

   task report_mismatch(string what, longint got, longint want);
      errors++;
      $display("%0t mismatch in response word %0d: %s got %0d expected %0d",
               $realtime, words_checked, what, got, want);
   endtask

   // Compare a response word with the oldest queued date
   task check_response(ectc_pkg::ectc_result_type got);
      ectc_pkg::ectc_result_type want;
      if (pending_dates.size() == 0) begin
         report_mismatch("unexpected word, second", got.second, -1);
      end else begin
         want = pending_dates.pop_front();
         if (got.second != want.second) report_mismatch("second", got.second, want.second);
         if (got.minute != want.minute) report_mismatch("minute", got.minute, want.minute);
         if (got.hour != want.hour) report_mismatch("hour", got.hour, want.hour);
         if (got.year != want.year) report_mismatch("year_since_1900", got.year, want.year);
         if (got.month != want.month) report_mismatch("month", got.month, want.month);
         if (got.day != want.day) report_mismatch("day_of_month", got.day, want.day);
      end
      words_checked++;
   endtask
endclass

module epoch_seconds_to_calendar_core_tb;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT_WORD = 200;
   localparam int PHASE_WORDS = 170;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic signed [4:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [32:0] req_epoch_seconds = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [5:0] rsp_second;
   logic [5:0] rsp_minute;
   logic [4:0] rsp_hour;
   logic [7:0] rsp_year_since_1900;
   logic [3:0] rsp_month;
   logic [4:0] rsp_day_of_month;

   calendar_scoreboard sb = new();
   logic signed [4:0] tz_now = '0;
   int send_idle_pct = 28;
   int recv_idle_pct = 69;
   int cycle_count = 0;
   int words_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   ectc_pkg::ectc_result_type got_word;

   epoch_seconds_to_calendar_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_epoch_seconds   (req_epoch_seconds),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_second          (rsp_second),
      .rsp_minute          (rsp_minute),
      .rsp_hour            (rsp_hour),
      .rsp_year_since_1900 (rsp_year_since_1900),
      .rsp_month           (rsp_month),
      .rsp_day_of_month    (rsp_day_of_month)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort a run that hangs
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Take response words, check them, and drive ready with idles and one long hold
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word.second = rsp_second;
         got_word.minute = rsp_minute;
         got_word.hour = rsp_hour;
         got_word.year = rsp_year_since_1900;
         got_word.month = rsp_month;
         got_word.day = rsp_day_of_month;
         sb.check_response(got_word);
         words_seen++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && words_seen >= HOLD_AT_WORD) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request word and hold it until accepted
   task send_word(logic signed [32:0] secs);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      sb.note_request(secs, tz_now);
   endtask

   task write_offset(logic signed [4:0] tz);
      csr_wr_en <= 1'b1;
      csr_wr_data <= tz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tz_now = tz;
   endtask

   // Hold the sender until every queued date has come back
   task wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   logic signed [32:0] plain_list[15];
   logic signed [32:0] secs;
   logic signed [4:0] tz_plan[6];
   longint base;
   int sel;
   int k;

   initial begin
      // field extremes, clamping, leap days and year ends
      plain_list = '{33'sd0, -33'sd1, 33'sh1_0000_0000, 33'sh0_FFFF_FFFF,
                     33'sd59, 33'sd3599, 33'sd86399, 33'sd31535999,
                     33'sd68169600, 33'sd951782399, 33'sd951782400,
                     33'sd951868799, 33'sd951868800, 33'sd978307199,
                     33'sd4107456000};
      tz_plan = '{-5'sd16, 5'sd15, -5'sd12, 5'sd14, 5'($urandom), 5'sd0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_offset(5'sd0);
      foreach (plain_list[i]) send_word(plain_list[i]);
      wait_drained();
      // most negative offset: clamp edge at minus sixteen hours
      write_offset(-5'sd16);
      send_word(33'sd57599);
      send_word(33'sd57600);
      wait_drained();
      // most positive offset: latest date and the clamp edge
      write_offset(5'sd15);
      send_word(33'sh0_FFFF_FFFF);
      send_word(-33'sd54000);
      send_word(-33'sd54001);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_offset(tz_plan[p]);
         case (p % 3)
            0: begin send_idle_pct = 28; recv_idle_pct = 69; end
            1: begin send_idle_pct = 69; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         repeat (PHASE_WORDS) begin
            sel = $urandom_range(99);
            k = $urandom_range(33);
            if (sel < 15) begin
               secs = {1'($urandom), 32'($urandom)};
            end else if (sel < 50) begin
               secs = {1'b0, 32'($urandom)};
            end else if (sel < 70) begin
               // window around a leap day
               base = longint'(730 + 1461 * k + 57 + $urandom_range(4)) * 86400
                      + $urandom_range(86399);
               secs = base[32:0];
            end else if (sel < 85) begin
               // a few seconds around a new year
               case ($urandom_range(3))
                  0: base = longint'(1461 * k) * 86400;
                  1: base = longint'(1461 * k + 365) * 86400;
                  2: base = longint'(1461 * k + 730) * 86400;
                  default: base = longint'(1461 * k + 1096) * 86400;
               endcase
               base = base + $urandom_range(4) - 2;
               secs = base[32:0];
            end else begin
               base = longint'($urandom_range(200000)) - 100000;
               secs = base[32:0];
            end
            send_word(secs);
         end
         wait_drained();
      end

      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
